[sv/mdbp_pkg.sv]
// ----------------------------------------------------------------------------
// MDB frame parser package
// Shared constants, codes and interface types of the receive-side parser.
// ----------------------------------------------------------------------------
package mdbp_pkg;

   localparam int CMD_COUNT     = 8;
   localparam int CMD_W         = $clog2(CMD_COUNT);
   localparam int SUB_COUNT     = 8;
   localparam int SUB_W         = $clog2(SUB_COUNT);
   localparam int SUB_ADDR_W    = CMD_W + SUB_W;
   localparam int SUB_DEPTH     = CMD_COUNT * SUB_COUNT;
   localparam int LEN_W         = 6;
   localparam int MAX_FRAME     = 36;
   localparam int BYTE_W        = 8;
   localparam int WORD_W        = 9;
   localparam int EVENT_W       = 3;
   localparam logic [BYTE_W-1:0] ADDR_MASK      = 8'hF8;
   localparam logic [BYTE_W-1:0] DEV_ADDR_RESET = 8'd16;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RECV = 2'd1,
      PH_CSUM = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE      = 3'd0,
      EV_BYTE      = 3'd1,
      EV_ACCEPT    = 3'd2,
      EV_CSUM_ERR  = 3'd3,
      EV_UNK_CMD   = 3'd4,
      EV_UNK_SUB   = 3'd5
   } event_type;

   typedef enum logic {
      OP_BUS_WORD = 1'b0,
      OP_REGISTER = 1'b1
   } op_type;

   typedef struct packed {
      logic                  en;
      logic [SUB_ADDR_W-1:0] addr;
      logic [LEN_W-1:0]      len;
   } sub_wr_type;

   typedef struct packed {
      logic                  en;
      logic [SUB_ADDR_W-1:0] addr;
   } sub_rd_type;

   typedef struct packed {
      logic             valid;
      logic [LEN_W-1:0] len;
   } sub_entry_type;

endpackage

[sv/mdb_peripheral_frame_parser.sv]
// ----------------------------------------------------------------------------
// MDB peripheral frame parser
// The request is held in the input register and its result in the result register.
// Throughput: one request per cycle while the result side does not stall;
// input register, one parse stage, result register. Synchronous reset: idle,
// length tables empty, device address 16.
// ----------------------------------------------------------------------------
module mdb_peripheral_frame_parser
   import mdbp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [BYTE_W-1:0]   csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [WORD_W-1:0]   req_bus_word,
   input  logic [CMD_W-1:0]    req_reg_command,
   input  logic                req_reg_with_sub,
   input  logic [SUB_W-1:0]    req_reg_subcommand,
   input  logic [LEN_W-1:0]    req_reg_length,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [EVENT_W-1:0]  rsp_event_res,
   output logic [CMD_W-1:0]    rsp_frame_command,
   output logic [SUB_W-1:0]    rsp_frame_subcommand,
   output logic                rsp_frame_has_sub,
   output logic [BYTE_W-1:0]   rsp_data_byte,
   output logic [LEN_W-1:0]    rsp_byte_index
);

   // configuration
   logic [BYTE_W-1:0] dev_addr_ff;

   // input register
   logic              item_valid_ff, item_valid_in;
   logic              item_cmd_ff;
   logic [WORD_W-1:0] item_word_ff;
   logic [CMD_W-1:0]  item_rcmd_ff;
   logic              item_rsub_en_ff;
   logic [SUB_W-1:0]  item_rsub_ff;
   logic [LEN_W-1:0]  item_rlen_ff;

   // frame state
   phase_type         phase_ff, phase_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [SUB_W-1:0]  sub_ff, sub_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0]  exp_ff, exp_in;
   logic              hs_ff, hs_in;

   // command table
   logic [CMD_COUNT-1:0] ct_valid_ff;
   logic [CMD_COUNT-1:0] ct_sub_ff;
   logic [LEN_W-1:0]     ct_len_ff [CMD_COUNT];
   logic                 ct_wr_en;
   logic                 ct_wr_sub;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   event_type         ev_ff, ev_in;
   logic [CMD_W-1:0]  fc_ff, fc_in;
   logic [SUB_W-1:0]  fs_ff, fs_in;
   logic              fh_ff, fh_in;
   logic [BYTE_W-1:0] db_ff, db_in;
   logic [LEN_W-1:0]  bi_ff, bi_in;

   logic              accept;
   logic              advance;
   logic [BYTE_W-1:0] data;
   logic [CMD_W-1:0]  addr_cmd;
   logic [LEN_W-1:0]  idx;
   logic              done;
   logic              sub_ok;
   sub_wr_type        sub_wr;
   sub_rd_type        sub_rd;
   sub_entry_type     sub_entry;

   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign data     = item_word_ff[BYTE_W-1:0];
   assign addr_cmd = data[CMD_W-1:0];

   assign sub_rd.en   = accept;
   assign sub_rd.addr = {cmd_in, req_bus_word[SUB_W-1:0]};

   mdbp_sub_table u_sub_table (
      .clock (clock),
      .reset (reset),
      .wr    (sub_wr),
      .rd    (sub_rd),
      .entry (sub_entry)
   );

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   // parse stage
   always_comb begin
      phase_in    = phase_ff;
      cmd_in      = cmd_ff;
      sub_in      = sub_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      exp_in      = exp_ff;
      hs_in       = hs_ff;
      ct_wr_en    = 1'b0;
      ct_wr_sub   = 1'b0;
      sub_wr.en   = 1'b0;
      sub_wr.addr = {item_rcmd_ff, item_rsub_ff};
      sub_wr.len  = item_rlen_ff;
      ev_in       = EV_NONE;
      fc_in       = cmd_ff;
      fs_in       = sub_ff;
      fh_in       = (phase_ff != PH_IDLE) && hs_ff;
      db_in       = '0;
      bi_in       = '0;
      idx         = '0;
      done        = 1'b0;
      sub_ok      = 1'b0;

      if (item_valid_ff) begin
         if (item_cmd_ff == OP_REGISTER) begin
            ct_wr_en  = 1'b1;
            ct_wr_sub = item_rsub_en_ff;
            sub_wr.en = item_rsub_en_ff;
            if (item_rcmd_ff == cmd_ff) begin
               hs_in = item_rsub_en_ff;
            end
            fh_in = (phase_ff != PH_IDLE) && hs_in;
         end else begin
            if (item_word_ff[WORD_W-1]) begin
               phase_in = PH_IDLE;
               cmd_in   = '0;
               sub_in   = '0;
               cnt_in   = '0;
               sum_in   = '0;
               exp_in   = '0;
               hs_in    = 1'b0;
               fc_in    = '0;
               fs_in    = '0;
               fh_in    = 1'b0;
               if ((data & ADDR_MASK) != (dev_addr_ff & ADDR_MASK)) begin
                  done = 1'b1;
               end else if (!ct_valid_ff[addr_cmd]) begin
                  done  = 1'b1;
                  ev_in = EV_UNK_CMD;
                  fc_in = addr_cmd;
               end else begin
                  phase_in = PH_RECV;
                  cmd_in   = addr_cmd;
                  exp_in   = ct_len_ff[addr_cmd];
                  hs_in    = ct_sub_ff[addr_cmd];
               end
            end

            if (!done) begin
               unique case (phase_in)
                  PH_RECV: begin
                     idx    = cnt_in;
                     cnt_in = idx + 1'b1;
                     sum_in = sum_in + data;
                     sub_ok = 1'b1;
                     if ((cnt_in == LEN_W'(2)) && hs_in) begin
                        sub_ok = (data < BYTE_W'(SUB_COUNT)) && sub_entry.valid;
                        if (sub_ok) begin
                           sub_in = data[SUB_W-1:0];
                           exp_in = sub_entry.len;
                        end
                     end
                     if (!sub_ok) begin
                        ev_in    = EV_UNK_SUB;
                        fc_in    = cmd_in;
                        fs_in    = data[SUB_W-1:0];
                        fh_in    = 1'b1;
                        phase_in = PH_IDLE;
                        cmd_in   = '0;
                        sub_in   = '0;
                        cnt_in   = '0;
                        sum_in   = '0;
                        exp_in   = '0;
                        hs_in    = 1'b0;
                     end else begin
                        if ((cnt_in == exp_in) || (cnt_in >= LEN_W'(MAX_FRAME))) begin
                           phase_in = PH_CSUM;
                        end
                        ev_in = EV_BYTE;
                        fc_in = cmd_in;
                        fs_in = sub_in;
                        fh_in = hs_in;
                        db_in = data;
                        bi_in = idx;
                     end
                  end
                  PH_CSUM: begin
                     fc_in = cmd_in;
                     fs_in = sub_in;
                     fh_in = hs_in;
                     if (data == sum_in) begin
                        phase_in = PH_DONE;
                        ev_in    = EV_ACCEPT;
                     end else begin
                        ev_in    = EV_CSUM_ERR;
                        phase_in = PH_IDLE;
                        cmd_in   = '0;
                        sub_in   = '0;
                        cnt_in   = '0;
                        sum_in   = '0;
                        exp_in   = '0;
                        hs_in    = 1'b0;
                     end
                  end
                  PH_IDLE, PH_DONE: begin
                     fc_in = cmd_in;
                     fs_in = sub_in;
                     fh_in = (phase_in != PH_IDLE) && hs_in;
                  end
                  default: begin
                     ev_in = EV_NONE;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DEV_ADDR_RESET;
      end else if (csr_wr_en) begin
         dev_addr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_IDLE;
         cmd_ff        <= '0;
         sub_ff        <= '0;
         cnt_ff        <= '0;
         sum_ff        <= '0;
         exp_ff        <= '0;
         hs_ff         <= 1'b0;
         ct_valid_ff   <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            cmd_ff   <= cmd_in;
            sub_ff   <= sub_in;
            cnt_ff   <= cnt_in;
            sum_ff   <= sum_in;
            exp_ff   <= exp_in;
            hs_ff    <= hs_in;
            if (ct_wr_en) begin
               ct_valid_ff[item_rcmd_ff] <= 1'b1;
            end
         end
      end
   end

   // table payload; a command first seen through a subcommand entry has length 0
   always_ff @(posedge clock) begin
      if (reset) begin
         ct_sub_ff <= '0;
         for (int i = 0; i < CMD_COUNT; i++) begin
            ct_len_ff[i] <= '0;
         end
      end else if (advance && ct_wr_en) begin
         ct_sub_ff[item_rcmd_ff] <= ct_wr_sub;
         if (!ct_wr_sub) begin
            ct_len_ff[item_rcmd_ff] <= item_rlen_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_cmd_ff     <= req_cmd;
         item_word_ff    <= req_bus_word;
         item_rcmd_ff    <= req_reg_command;
         item_rsub_en_ff <= req_reg_with_sub;
         item_rsub_ff    <= req_reg_subcommand;
         item_rlen_ff    <= req_reg_length;
      end
      if (advance) begin
         ev_ff <= ev_in;
         fc_ff <= fc_in;
         fs_ff <= fs_in;
         fh_ff <= fh_in;
         db_ff <= db_in;
         bi_ff <= bi_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_res        = ev_ff;
   assign rsp_frame_command    = fc_ff;
   assign rsp_frame_subcommand = fs_ff;
   assign rsp_frame_has_sub    = fh_ff;
   assign rsp_data_byte        = db_ff;
   assign rsp_byte_index       = bi_ff;

endmodule

[sv/mdbp_sub_table.sv]
// ----------------------------------------------------------------------------
// MDB subcommand length table
// Length memory with per-entry valid flags. The read is taken when a request
// enters and held; a write at the same edge to the same entry is forwarded.
// ----------------------------------------------------------------------------
module mdbp_sub_table
   import mdbp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sub_wr_type    wr,
   input  sub_rd_type    rd,
   output sub_entry_type entry
);

   logic [LEN_W-1:0]      mem [SUB_DEPTH];
   logic [SUB_DEPTH-1:0]  valid_ff;
   logic [SUB_ADDR_W-1:0] addr_ff;
   logic [LEN_W-1:0]      len_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.len;
      end
      if (rd.en) begin
         addr_ff <= rd.addr;
         if (wr.en && (wr.addr == rd.addr)) begin
            len_ff <= wr.len;
         end else begin
            len_ff <= mem[rd.addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign entry.valid = valid_ff[addr_ff];
   assign entry.len   = len_ff;

endmodule

[verif/mdb_peripheral_frame_parser_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MDB frame parser checker
// Watches the request, result and address-write ports of the parser, keeps
// its own copy of the frame state and length tables, predicts one result per
// accepted request and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module mdb_peripheral_frame_parser_checker
   import mdbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [BYTE_W-1:0]  csr_wr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_cmd,
   input  logic [WORD_W-1:0]  req_bus_word,
   input  logic [CMD_W-1:0]   req_reg_command,
   input  logic               req_reg_with_sub,
   input  logic [SUB_W-1:0]   req_reg_subcommand,
   input  logic [LEN_W-1:0]   req_reg_length,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [EVENT_W-1:0] rsp_event_res,
   input  logic [CMD_W-1:0]   rsp_frame_command,
   input  logic [SUB_W-1:0]   rsp_frame_subcommand,
   input  logic               rsp_frame_has_sub,
   input  logic [BYTE_W-1:0]  rsp_data_byte,
   input  logic [LEN_W-1:0]   rsp_byte_index,
   output int                 fail_count,
   output int                 outstanding
);

   typedef struct packed {
      event_type         ev;
      logic [CMD_W-1:0]  cmd;
      logic [SUB_W-1:0]  sub;
      logic              has_sub;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  idx;
   } frame_result_type;

   // frame state
   phase_type         st_phase;
   logic [CMD_W-1:0]  st_cmd;
   logic [SUB_W-1:0]  st_sub;
   logic [LEN_W-1:0]  st_count;
   logic [BYTE_W-1:0] st_sum;
   logic [LEN_W-1:0]  st_len;
   logic [BYTE_W-1:0] addr_reg;

   // length tables
   logic              cmd_valid [CMD_COUNT];
   logic              cmd_sub   [CMD_COUNT];
   logic [LEN_W-1:0]  cmd_len   [CMD_COUNT];
   logic              sub_valid [SUB_DEPTH];
   logic [LEN_W-1:0]  sub_len   [SUB_DEPTH];

   frame_result_type  expected_q [$];
   frame_result_type  oldest;

   function automatic void close_frame();
      st_phase = PH_IDLE;
      st_cmd   = '0;
      st_sub   = '0;
      st_count = '0;
      st_sum   = '0;
      st_len   = '0;
   endfunction

   function automatic void reset_model();
      addr_reg = DEV_ADDR_RESET;
      close_frame();
      for (int i = 0; i < CMD_COUNT; i++) begin
         cmd_valid[i] = 1'b0;
         cmd_sub[i]   = 1'b0;
         cmd_len[i]   = '0;
      end
      for (int i = 0; i < SUB_DEPTH; i++) begin
         sub_valid[i] = 1'b0;
         sub_len[i]   = '0;
      end
   endfunction

   function automatic logic frame_sub();
      return (st_phase != PH_IDLE) && cmd_sub[st_cmd];
   endfunction

   function automatic frame_result_type outcome(event_type ev, logic [CMD_W-1:0] c,
                                                logic [SUB_W-1:0] s, logic h,
                                                logic [BYTE_W-1:0] d,
                                                logic [LEN_W-1:0] i);
      frame_result_type r;
      r.ev      = ev;
      r.cmd     = c;
      r.sub     = s;
      r.has_sub = h;
      r.data    = d;
      r.idx     = i;
      return r;
   endfunction

   function automatic frame_result_type parse_request(logic op, logic [WORD_W-1:0] word,
                                                      logic [CMD_W-1:0] rc, logic rws,
                                                      logic [SUB_W-1:0] rs,
                                                      logic [LEN_W-1:0] rl);
      logic [BYTE_W-1:0]     b;
      logic [CMD_W-1:0]      c;
      logic [SUB_W-1:0]      s;
      logic                  h;
      logic [LEN_W-1:0]      pos;
      logic [SUB_ADDR_W-1:0] slot;
      b = word[BYTE_W-1:0];

      if (op == OP_REGISTER) begin
         if (rws) begin
            cmd_valid[rc]       = 1'b1;
            cmd_sub[rc]         = 1'b1;
            sub_valid[{rc, rs}] = 1'b1;
            sub_len[{rc, rs}]   = rl;
         end else begin
            cmd_valid[rc] = 1'b1;
            cmd_sub[rc]   = 1'b0;
            cmd_len[rc]   = rl;
         end
         return outcome(EV_NONE, st_cmd, st_sub, frame_sub(), '0, '0);
      end

      if (word[WORD_W-1]) begin
         close_frame();
         if ((b & ADDR_MASK) != (addr_reg & ADDR_MASK))
            return outcome(EV_NONE, '0, '0, 1'b0, '0, '0);
         c = b[CMD_W-1:0];
         if (!cmd_valid[c])
            return outcome(EV_UNK_CMD, c, '0, 1'b0, '0, '0);
         st_phase = PH_RECV;
         st_cmd   = c;
         st_len   = cmd_len[c];
      end

      if (st_phase == PH_RECV) begin
         pos      = st_count;
         h        = frame_sub();
         st_count = st_count + 1'b1;
         st_sum   = st_sum + b;
         if (st_count == 2 && h) begin
            slot = {st_cmd, b[SUB_W-1:0]};
            if (b >= SUB_COUNT || !sub_valid[slot]) begin
               c = st_cmd;
               close_frame();
               return outcome(EV_UNK_SUB, c, b[SUB_W-1:0], 1'b1, '0, '0);
            end
            st_sub = b[SUB_W-1:0];
            st_len = sub_len[slot];
         end
         if (st_count == st_len || st_count >= MAX_FRAME)
            st_phase = PH_CSUM;
         return outcome(EV_BYTE, st_cmd, st_sub, h, b, pos);
      end

      if (st_phase == PH_CSUM) begin
         c = st_cmd;
         s = st_sub;
         h = frame_sub();
         if (b == st_sum) begin
            st_phase = PH_DONE;
            return outcome(EV_ACCEPT, c, s, h, '0, '0);
         end
         close_frame();
         return outcome(EV_CSUM_ERR, c, s, h, '0, '0);
      end

      return outcome(EV_NONE, st_cmd, st_sub, frame_sub(), '0, '0);
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result: event_res %0d", rsp_event_res);
               fail_count++;
            end else begin
               oldest = expected_q.pop_front();
               check_field("event_res", oldest.ev, rsp_event_res);
               check_field("frame_command", oldest.cmd, rsp_frame_command);
               check_field("frame_subcommand", oldest.sub, rsp_frame_subcommand);
               check_field("frame_has_sub", oldest.has_sub, rsp_frame_has_sub);
               check_field("data_byte", oldest.data, rsp_data_byte);
               check_field("byte_index", oldest.idx, rsp_byte_index);
            end
         end
         if (csr_wr_en)
            addr_reg = csr_wr_data;
         if (req_valid && !req_stall)
            expected_q.push_back(parse_request(req_cmd, req_bus_word, req_reg_command,
                                               req_reg_with_sub, req_reg_subcommand,
                                               req_reg_length));
      end
      outstanding = expected_q.size();
   end

endmodule

[verif/mdb_peripheral_frame_parser_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MDB frame parser testbench
// Directed frames and registrations, then random well-formed, corrupted and
// broken frames mixed with registrations and stray bus words over several
// device addresses, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module mdb_peripheral_frame_parser_test;
   import mdbp_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 5000;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [BYTE_W-1:0]  csr_wr_data;
   logic               req_valid;
   logic               req_stall;
   logic               req_cmd;
   logic [WORD_W-1:0]  req_bus_word;
   logic [CMD_W-1:0]   req_reg_command;
   logic               req_reg_with_sub;
   logic [SUB_W-1:0]   req_reg_subcommand;
   logic [LEN_W-1:0]   req_reg_length;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [EVENT_W-1:0] rsp_event_res;
   logic [CMD_W-1:0]   rsp_frame_command;
   logic [SUB_W-1:0]   rsp_frame_subcommand;
   logic               rsp_frame_has_sub;
   logic [BYTE_W-1:0]  rsp_data_byte;
   logic [LEN_W-1:0]   rsp_byte_index;
   int                 fail_count;
   int                 outstanding;

   // stimulus view of the tables, only used to shape frames
   logic [BYTE_W-1:0]  dev_addr = DEV_ADDR_RESET;
   bit                 cmd_ok   [CMD_COUNT];
   bit                 uses_sub [CMD_COUNT];
   int                 cmd_len  [CMD_COUNT];
   bit                 sub_ok   [SUB_DEPTH];
   int                 sub_len  [SUB_DEPTH];

   int                 items_sent = 0;
   int                 quiet_cycles;
   bit                 calm = 1'b0;
   bit                 hold_off = 1'b0;

   mdb_peripheral_frame_parser u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_bus_word         (req_bus_word),
      .req_reg_command      (req_reg_command),
      .req_reg_with_sub     (req_reg_with_sub),
      .req_reg_subcommand   (req_reg_subcommand),
      .req_reg_length       (req_reg_length),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_res        (rsp_event_res),
      .rsp_frame_command    (rsp_frame_command),
      .rsp_frame_subcommand (rsp_frame_subcommand),
      .rsp_frame_has_sub    (rsp_frame_has_sub),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_byte_index       (rsp_byte_index)
   );

   mdb_peripheral_frame_parser_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_bus_word         (req_bus_word),
      .req_reg_command      (req_reg_command),
      .req_reg_with_sub     (req_reg_with_sub),
      .req_reg_subcommand   (req_reg_subcommand),
      .req_reg_length       (req_reg_length),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_res        (rsp_event_res),
      .rsp_frame_command    (rsp_frame_command),
      .rsp_frame_subcommand (rsp_frame_subcommand),
      .rsp_frame_has_sub    (rsp_frame_has_sub),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_byte_index       (rsp_byte_index),
      .fail_count           (fail_count),
      .outstanding          (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_req(op_type op, logic [WORD_W-1:0] word, logic [CMD_W-1:0] rc,
                           logic rws, logic [SUB_W-1:0] rs, logic [LEN_W-1:0] rl);
      int gap;
      req_valid          <= 1'b1;
      req_cmd            <= op;
      req_bus_word       <= word;
      req_reg_command    <= rc;
      req_reg_with_sub   <= rws;
      req_reg_subcommand <= rs;
      req_reg_length     <= rl;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_word(logic [WORD_W-1:0] w);
      send_req(OP_BUS_WORD, w, 3'($urandom), 1'($urandom), 3'($urandom), 6'($urandom));
   endtask

   task automatic add_entry(logic [CMD_W-1:0] c, logic ws, logic [SUB_W-1:0] s,
                            logic [LEN_W-1:0] len);
      send_req(OP_REGISTER, 9'($urandom), c, ws, s, len);
      cmd_ok[c] = 1'b1;
      if (ws) begin
         uses_sub[c]     = 1'b1;
         sub_ok[{c, s}]  = 1'b1;
         sub_len[{c, s}] = len;
      end else begin
         uses_sub[c] = 1'b0;
         cmd_len[c]  = len;
      end
   endtask

   // address byte, optional subcommand byte, payload, checksum; sometimes
   // cut short or with a bad checksum
   task automatic send_frame();
      logic [CMD_W-1:0]  c;
      logic [SUB_W-1:0]  s;
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      int                n;
      int                cut;
      c = 3'($urandom);
      s = 3'($urandom);
      for (int k = 0; k < 4 && uses_sub[c] && !sub_ok[{c, s}]; k++)
         s = 3'($urandom);
      if (uses_sub[c] && cmd_len[c] != 1) begin
         n = sub_len[{c, s}];
         if (n < 2)
            n = MAX_FRAME;
      end else begin
         n = cmd_len[c];
         if (n == 0)
            n = MAX_FRAME;
      end
      if (n > MAX_FRAME)
         n = MAX_FRAME;
      cut = ($urandom_range(0, 99) < 8) ? $urandom_range(1, n) : n + 1;
      if (!cmd_ok[c]) begin
         n   = 1;
         cut = 1;
      end
      sum = '0;
      for (int k = 0; k < n && k < cut; k++) begin
         if (k == 0)
            b = {dev_addr[7:3], c};
         else if (k == 1 && uses_sub[c])
            b = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'(s);
         else
            b = 8'($urandom);
         sum = sum + b;
         send_word({k == 0, b});
      end
      if (cut > n) begin
         if ($urandom_range(0, 9) == 0)
            sum = sum ^ 8'($urandom_range(1, 255));
         send_word({1'b0, sum});
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
   endtask

   task automatic write_address(logic [BYTE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dev_addr     = value;
   endtask

   // result side: random stalls, one long hold when asked
   initial begin
      int n;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            n = pick_gap();
            rsp_stall <= (n != 0);
            repeat ((n != 0) ? n : $urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[mdb_peripheral_frame_parser] ERROR");
         $finish;
      end
   end

   initial begin
      logic [BYTE_W-1:0] addr_plan [5];
      logic [LEN_W-1:0]  len;
      int                phase_end;
      int                r;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_valid          <= 1'b0;
      req_cmd            <= OP_BUS_WORD;
      req_bus_word       <= '0;
      req_reg_command    <= '0;
      req_reg_with_sub   <= 1'b0;
      req_reg_subcommand <= '0;
      req_reg_length     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: device address 16 from reset
      send_word(9'h0A5);                 // data while idle
      send_word(9'h117);                 // unknown command
      add_entry(3'd0, 1'b0, 3'd0, 6'd1);
      send_word(9'h110);                 // one-byte frame, good checksum
      send_word(9'h010);
      send_word(9'h0FF);                 // data after accepted frame
      add_entry(3'd1, 1'b0, 3'd0, 6'd3);
      send_word(9'h111);                 // checksum error
      send_word(9'h0FF);
      send_word(9'h000);
      send_word(9'h055);
      add_entry(3'd2, 1'b1, 3'd5, 6'd4);
      send_word(9'h112);                 // subcommand frame, accepted
      send_word(9'h005);
      send_word(9'h0AA);
      send_word(9'h033);
      send_word(9'h0F4);
      send_word(9'h112);                 // subcommand out of range
      send_word(9'h0C8);
      send_word(9'h112);                 // subcommand without entry
      send_word(9'h003);
      send_word(9'h111);                 // foreign address aborts
      send_word(9'h042);
      send_word(9'h1FF);
      add_entry(3'd7, 1'b0, 3'd7, 6'd63);
      add_entry(3'd6, 1'b0, 3'd0, 6'd0);
      add_entry(3'd3, 1'b1, 3'd7, 6'd1);

      addr_plan = '{8'd0, 8'd248, 8'd255, 8'($urandom), 8'd16};
      for (int p = 0; p < 5; p++) begin
         wait_idle();
         write_address(addr_plan[p]);
         calm      = (p == 3);
         hold_off  = (p == 1);
         phase_end = items_sent + 185;
         while (items_sent < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
               send_frame();
            end else if (r < 84) begin
               len = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(1, 8));
               add_entry(3'($urandom), $urandom_range(0, 2) == 0, 3'($urandom), len);
            end else if (r < 92) begin
               send_word({1'b0, 8'($urandom)});
            end else begin
               send_word(9'($urandom));
            end
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("[mdb_peripheral_frame_parser] OK");
      else
         $display("[mdb_peripheral_frame_parser] ERROR");
      $finish;
   end

endmodule
